### sv/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types, constants and calendar helpers
// sequencer states, datapath control/status structs, stride tables, leap rule
// ----------------------------------------------------------------------------
package gda_pkg;

   localparam int YEAR_W     = 16;
   localparam int DIFF_LIMIT = 4194303;

   // floor(y / 100) for y < 2**16 as (y * RECIP100) >> RECIP_SHIFT
   localparam logic [16:0] RECIP100    = 17'd83887;
   localparam int          RECIP_SHIFT = 23;

   // 400-year, century, 4-year and 1-year strides
   localparam logic [17:0] STRIDE_DAYS  [4] = '{18'd146097, 18'd36524, 18'd1461, 18'd365};
   localparam logic [8:0]  STRIDE_YEARS [4] = '{9'd400, 9'd100, 9'd4, 9'd1};

   localparam logic [1:0] IDX_CENTURY = 2'd1;
   localparam logic [1:0] IDX_YEAR    = 2'd3;
   localparam logic [1:0] STRIDE_CAP  = 2'd3;

   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_TYEAR,
      ST_TMON,
      ST_TDAY,
      ST_DIFF,
      ST_MOVE,
      ST_CLIPLO,
      ST_CLIPHI,
      ST_FYEAR,
      ST_FLEAP,
      ST_FMON,
      ST_DONE
   } state_type;

   typedef enum logic {
      OPA_ACC,
      OPA_SA
   } opa_sel_type;

   typedef enum logic {
      OPB_EXT,
      OPB_SB
   } opb_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_RES,
      ACC_EXT
   } acc_mode_type;

   typedef struct packed {
      opa_sel_type  opa_sel;
      opb_sel_type  opb_sel;
      logic         sub;
      acc_mode_type acc_mode;
      logic         sa_we;
      logic         sb_we;
   } dp_ctrl_type;

   typedef struct packed {
      logic res_neg;
      logic res_zero;
   } dp_status_type;

   // gregorian leap rule without a divider
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [32:0]       prod;
      logic [9:0]        q;
      logic [YEAR_W-1:0] r;
      prod = {17'b0, y} * {16'b0, RECIP100};
      q    = prod[RECIP_SHIFT +: 10];
      r    = y - YEAR_W'({6'b0, q} * 16'd100);
      return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### sv/gregorian_date_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit: date move and day-difference engine
// proleptic gregorian calendar, years 1 to MAX_YEAR, one shared adder
// ----------------------------------------------------------------------------
// Each request carries dates A and B and a signed day offset. Kind 0 moves A
// by the offset and returns the new date; kind 1 returns the signed day count
// A minus B. Both report whether A is later than or equal to B. Input dates
// are clamped field by field first; a moved date outside 0001-01-01 to
// MAX_YEAR-12-31 saturates to the limit and raises out_of_range. One request
// is in work at a time: req_tready is high only while the sequencer idles,
// and a finished result waits in the output register, so the next request is
// taken while the previous response is still pending. Every step runs through
// a single add/subtract unit: each date goes to a day serial by 400-year,
// century, 4-year and 1-year strides and then month by month, and a moved
// serial is taken back apart the same way, one stride or one month per step.
// Once the output register is free the result is loaded into it and the
// sequencer returns to idle, where it takes the next transfer.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_unit #(
   parameter int MAX_YEAR = 9999
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // a_year[13:0] a_month[17:14] a_day[22:18] b_year[36:23] b_month[40:37]
   // b_day[45:41] offset[68:46] zero[71:69]
   input  logic [71:0] req_tdata,
   // kind[0]
   input  logic        req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // r_year[13:0] r_month[17:14] r_day[22:18] days_between[45:23]
   // a_greater[46] a_equal[47] out_of_range[48] zero[55:49]
   output logic [55:0] rsp_tdata
);

   localparam int YW = gda_pkg::YEAR_W;

   // serial width covers the top serial plus the largest offset, signed
   localparam int SER_W = $clog2(MAX_YEAR * 366 + 4194304) + 1;

   // serial of MAX_YEAR-12-31, with 0001-01-01 as zero
   localparam int TOP_SERIAL =
      MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 - 1;

   localparam logic [SER_W-1:0] TOP_S  = SER_W'(TOP_SERIAL);
   localparam logic [SER_W-1:0] LIM_S  = SER_W'(gda_pkg::DIFF_LIMIT);
   localparam logic [SER_W-1:0] NLIM_S = SER_W'(-gda_pkg::DIFF_LIMIT);
   localparam logic [YW-1:0]    MAXY   = YW'(MAX_YEAR);

   // sequencer and working registers
   gda_pkg::state_type state_ff, state_in;
   logic [1:0]    idx_ff, idx_in;     // stride select
   logic [1:0]    cnt_ff, cnt_in;     // strides taken at century/year level
   logic [YW-1:0] y_ff, y_in;         // elapsed years, then result year
   logic [3:0]    m_ff, m_in;         // month walker
   logic [3:0]    mlim_ff, mlim_in;   // clamped month of the date in work
   logic [4:0]    d_ff, d_in;         // clamped day of the date in work
   logic          leap_ff, leap_in;
   logic          sel_b_ff, sel_b_in; // date B in work
   logic          oor_ff, oor_in;
   logic          gt_ff, gt_in;
   logic          eq_ff, eq_in;

   // captured request
   logic [68:0] raw_ff;
   logic        kind_ff;

   // response register
   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;
   logic        out_load;

   logic        accept;

   // shared unit interface
   gda_pkg::dp_ctrl_type   ctrl;
   gda_pkg::dp_status_type status;
   logic [SER_W-1:0]       operand;
   logic [SER_W-1:0]       acc;

   // clamped fields of the date in work
   logic [13:0]   raw_year;
   logic [3:0]    raw_month;
   logic [4:0]    raw_day;
   logic [YW-1:0] year_x;
   logic [YW-1:0] year_c;
   logic [3:0]    month_c;
   logic [4:0]    len_c;
   logic [4:0]    day_c;
   logic [YW-1:0] leap_year;
   logic          leap_now;

   // stride helpers
   logic [YW-1:0]    stride_years;
   logic [SER_W-1:0] stride_days;
   logic             y_ge;
   logic             stride_cap;

   // response fields
   logic [13:0] ry_f;
   logic [3:0]  rm_f;
   logic [4:0]  rd_f;
   logic [22:0] diff_f;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == gda_pkg::ST_IDLE);

   // clamp of the selected input date
   always_comb begin
      raw_year  = sel_b_ff ? raw_ff[36:23] : raw_ff[13:0];
      raw_month = sel_b_ff ? raw_ff[40:37] : raw_ff[17:14];
      raw_day   = sel_b_ff ? raw_ff[45:41] : raw_ff[22:18];
      year_x    = {2'b0, raw_year};

      if (year_x == '0) begin
         year_c = YW'(1);
      end else if (year_x > MAXY) begin
         year_c = MAXY;
      end else begin
         year_c = year_x;
      end

      if (raw_month == 4'd0) begin
         month_c = 4'd1;
      end else if (raw_month > gda_pkg::MONTH_DEC) begin
         month_c = gda_pkg::MONTH_DEC;
      end else begin
         month_c = raw_month;
      end

      // one leap evaluator, shared by load and year recovery
      leap_year = (state_ff == gda_pkg::ST_FLEAP) ? y_ff : year_c;
      leap_now  = gda_pkg::is_leap(leap_year);

      len_c = gda_pkg::month_len(leap_now, month_c);
      if (raw_day == 5'd0) begin
         day_c = 5'd1;
      end else if (raw_day > len_c) begin
         day_c = len_c;
      end else begin
         day_c = raw_day;
      end
   end

   assign stride_years = {7'b0, gda_pkg::STRIDE_YEARS[idx_ff]};
   assign stride_days  = SER_W'(gda_pkg::STRIDE_DAYS[idx_ff]);
   assign y_ge         = (y_ff >= stride_years);
   // at most three centuries per 400-year span and three plain years per 4-year span
   assign stride_cap   = ((idx_ff == gda_pkg::IDX_CENTURY) || (idx_ff == gda_pkg::IDX_YEAR))
                         && (cnt_ff == gda_pkg::STRIDE_CAP);

   // sequencer: next state and shared-unit control
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      y_in     = y_ff;
      m_in     = m_ff;
      mlim_in  = mlim_ff;
      d_in     = d_ff;
      leap_in  = leap_ff;
      sel_b_in = sel_b_ff;
      oor_in   = oor_ff;
      gt_in    = gt_ff;
      eq_in    = eq_ff;
      out_load = 1'b0;
      operand  = '0;
      ctrl     = '{opa_sel:  gda_pkg::OPA_ACC,
                   opb_sel:  gda_pkg::OPB_EXT,
                   sub:      1'b0,
                   acc_mode: gda_pkg::ACC_HOLD,
                   sa_we:    1'b0,
                   sb_we:    1'b0};

      unique case (state_ff)
         gda_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               sel_b_in = 1'b0;
               oor_in   = 1'b0;
               state_in = gda_pkg::ST_LOAD;
            end
         end

         // clamp the date in work, clear the accumulator
         gda_pkg::ST_LOAD: begin
            y_in          = year_c - YW'(1);
            mlim_in       = month_c;
            d_in          = day_c;
            leap_in       = leap_now;
            idx_in        = 2'd0;
            ctrl.acc_mode = gda_pkg::ACC_EXT;
            state_in      = gda_pkg::ST_TYEAR;
         end

         // elapsed years to days, largest stride first
         gda_pkg::ST_TYEAR: begin
            operand = stride_days;
            if (y_ge) begin
               ctrl.acc_mode = gda_pkg::ACC_RES;
               y_in          = y_ff - stride_years;
            end else if (idx_ff == gda_pkg::IDX_YEAR) begin
               m_in     = 4'd1;
               state_in = gda_pkg::ST_TMON;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end

         // whole months before the date's month
         gda_pkg::ST_TMON: begin
            operand = SER_W'(gda_pkg::month_len(leap_ff, m_ff));
            if (m_ff < mlim_ff) begin
               ctrl.acc_mode = gda_pkg::ACC_RES;
               m_in          = m_ff + 4'd1;
            end else begin
               state_in = gda_pkg::ST_TDAY;
            end
         end

         gda_pkg::ST_TDAY: begin
            operand = SER_W'(d_ff - 5'd1);
            if (sel_b_ff) begin
               ctrl.sb_we = 1'b1;
               state_in   = gda_pkg::ST_DIFF;
            end else begin
               ctrl.sa_we = 1'b1;
               sel_b_in   = 1'b1;
               state_in   = gda_pkg::ST_LOAD;
            end
         end

         // serial A minus serial B: order flags, and the count for kind 1
         gda_pkg::ST_DIFF: begin
            ctrl.opa_sel = gda_pkg::OPA_SA;
            ctrl.opb_sel = gda_pkg::OPB_SB;
            ctrl.sub     = 1'b1;
            gt_in        = !status.res_neg && !status.res_zero;
            eq_in        = status.res_zero;
            if (kind_ff) begin
               ctrl.acc_mode = gda_pkg::ACC_RES;
               state_in      = gda_pkg::ST_CLIPLO;
            end else begin
               state_in = gda_pkg::ST_MOVE;
            end
         end

         gda_pkg::ST_MOVE: begin
            ctrl.opa_sel  = gda_pkg::OPA_SA;
            operand       = SER_W'($signed(raw_ff[68:46]));
            ctrl.acc_mode = gda_pkg::ACC_RES;
            state_in      = gda_pkg::ST_CLIPLO;
         end

         // saturate against the lower limit
         gda_pkg::ST_CLIPLO: begin
            operand  = kind_ff ? NLIM_S : '0;
            ctrl.sub = 1'b1;
            y_in     = YW'(1);
            idx_in   = 2'd0;
            cnt_in   = 2'd0;
            if (status.res_neg) begin
               ctrl.acc_mode = gda_pkg::ACC_EXT;
               oor_in        = 1'b1;
               state_in      = kind_ff ? gda_pkg::ST_DONE : gda_pkg::ST_FYEAR;
            end else begin
               state_in = gda_pkg::ST_CLIPHI;
            end
         end

         // saturate against the upper limit
         gda_pkg::ST_CLIPHI: begin
            operand  = kind_ff ? LIM_S : TOP_S;
            ctrl.sub = 1'b1;
            if (!status.res_neg && !status.res_zero) begin
               ctrl.acc_mode = gda_pkg::ACC_EXT;
               oor_in        = 1'b1;
            end
            state_in = kind_ff ? gda_pkg::ST_DONE : gda_pkg::ST_FYEAR;
         end

         // peel strides off the serial to recover the year
         gda_pkg::ST_FYEAR: begin
            operand  = stride_days;
            ctrl.sub = 1'b1;
            if (!status.res_neg && !stride_cap) begin
               ctrl.acc_mode = gda_pkg::ACC_RES;
               y_in          = y_ff + stride_years;
               cnt_in        = cnt_ff + 2'd1;
            end else if (idx_ff == gda_pkg::IDX_YEAR) begin
               state_in = gda_pkg::ST_FLEAP;
            end else begin
               idx_in = idx_ff + 2'd1;
               cnt_in = 2'd0;
            end
         end

         gda_pkg::ST_FLEAP: begin
            leap_in  = leap_now;
            m_in     = 4'd1;
            state_in = gda_pkg::ST_FMON;
         end

         // peel whole months, what is left is the day
         gda_pkg::ST_FMON: begin
            operand  = SER_W'(gda_pkg::month_len(leap_ff, m_ff));
            ctrl.sub = 1'b1;
            if (!status.res_neg && (m_ff != gda_pkg::MONTH_DEC)) begin
               ctrl.acc_mode = gda_pkg::ACC_RES;
               m_in          = m_ff + 4'd1;
            end else begin
               state_in = gda_pkg::ST_DONE;
            end
         end

         // hand the result to the output register once it is free
         gda_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = gda_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gda_pkg::ST_IDLE;
         end
      endcase
   end

   gda_datapath #(
      .SER_W (SER_W)
   ) u_datapath (
      .clock   (clock),
      .ctrl    (ctrl),
      .operand (operand),
      .acc     (acc),
      .status  (status)
   );

   // response fields, unused ones read as zero
   always_comb begin
      if (kind_ff) begin
         ry_f   = 14'd0;
         rm_f   = 4'd0;
         rd_f   = 5'd0;
         diff_f = acc[22:0];
      end else begin
         ry_f   = y_ff[13:0];
         rm_f   = m_ff;
         rd_f   = acc[4:0] + 5'd1;
         diff_f = 23'd0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      y_ff     <= y_in;
      m_ff     <= m_in;
      mlim_ff  <= mlim_in;
      d_ff     <= d_in;
      leap_ff  <= leap_in;
      sel_b_ff <= sel_b_in;
      oor_ff   <= oor_in;
      gt_ff    <= gt_in;
      eq_ff    <= eq_in;
      if (accept) begin
         raw_ff  <= req_tdata[68:0];
         kind_ff <= req_tuser;
      end
      if (out_load) begin
         rsp_data_ff <= {7'b0, oor_ff, eq_ff, gt_ff, diff_f, rd_f, rm_f, ry_f};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/gda_datapath.sv
// ----------------------------------------------------------------------------
// gda_datapath: shared add/subtract unit with serial accumulator
// one adder serves every stride, month, offset and limit step
// ----------------------------------------------------------------------------
module gda_datapath #(
   parameter int SER_W = 24
) (
   input  logic                  clock,
   input  gda_pkg::dp_ctrl_type  ctrl,
   input  logic [SER_W-1:0]      operand,
   output logic [SER_W-1:0]      acc,
   output gda_pkg::dp_status_type status
);

   logic [SER_W-1:0] acc_ff, acc_in;
   logic [SER_W-1:0] sa_ff, sa_in;
   logic [SER_W-1:0] sb_ff, sb_in;
   logic [SER_W-1:0] opa, opb, res;

   always_comb begin
      unique case (ctrl.opa_sel)
         gda_pkg::OPA_SA:  opa = sa_ff;
         default:          opa = acc_ff;
      endcase
      unique case (ctrl.opb_sel)
         gda_pkg::OPB_SB:  opb = sb_ff;
         default:          opb = operand;
      endcase
      res = ctrl.sub ? (opa - opb) : (opa + opb);

      unique case (ctrl.acc_mode)
         gda_pkg::ACC_RES: acc_in = res;
         gda_pkg::ACC_EXT: acc_in = operand;
         default:          acc_in = acc_ff;
      endcase
      sa_in = ctrl.sa_we ? res : sa_ff;
      sb_in = ctrl.sb_we ? res : sb_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
   end

   assign acc             = acc_ff;
   assign status.res_neg  = res[SER_W-1];
   assign status.res_zero = (res == '0);

endmodule

### sv/gda_checker.sv
// ----------------------------------------------------------------------------
// gda_checker: port-level checks for the date arithmetic unit
// busy handshake, response hold and consistency of the response fields
// ----------------------------------------------------------------------------
module gda_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   logic [13:0] r_year;
   logic [3:0]  r_month;
   logic [4:0]  r_day;
   logic [22:0] days_between;
   logic        a_greater;
   logic        a_equal;

   assign r_year       = rsp_tdata[13:0];
   assign r_month      = rsp_tdata[17:14];
   assign r_day        = rsp_tdata[22:18];
   assign days_between = rsp_tdata[45:23];
   assign a_greater    = rsp_tdata[46];
   assign a_equal      = rsp_tdata[47];

   // one request in work: no second transfer right after the first
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a request is in work");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a response is either a date or a day count, never both
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (days_between == 23'd0)
                     || ((r_year == 14'd0) && (r_month == 4'd0) && (r_day == 5'd0)))
      else $error("date and day count both present");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(a_greater && a_equal))
      else $error("later and equal both set");

   a_date: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (r_month != 4'd0) |-> (r_day != 5'd0) && (r_month <= 4'd12))
      else $error("moved date out of calendar range");

endmodule

bind gregorian_date_arithmetic_unit gda_checker u_gda_checker (.*);
